@@ src/ecd_pkg.sv @@
// Shared types and constants for the epoch-to-civil-date pipeline.
// Depends on nothing; every other file in src imports it.
`timescale 1ns / 1ps
`default_nettype none

package ecd_pkg;

  typedef struct packed {
    logic signed [63:0] epoch_ms;
    logic signed [11:0] offset_minutes;
  } ecd_in_t;

  typedef struct packed {
    logic signed [29:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [9:0]         millisecond;
    logic               four_digit_year;
    logic               error;
  } ecd_out_t;

  typedef struct packed {
    logic vld;
    logic err;
  } ecd_side_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
  } ecd_tod_t;

  typedef struct packed {
    logic signed [29:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic               four_digit_year;
  } ecd_date_t;

  localparam logic signed [11:0] OffMax   = 12'sd1080;
  localparam logic signed [11:0] OffMin   = -12'sd1080;
  localparam logic signed [28:0] MsPerMin = 29'sd60000;
  localparam logic [26:0]        MsPerDay = 27'd86400000;
  localparam logic signed [37:0] DayShift = 38'sd719468;
  localparam logic [17:0]        EraDays  = 18'd146097;
  localparam logic [17:0]        EraLast  = 18'd146096;

  // Exact reciprocals: q = (x * M) >> S for every x of the stated width.
  localparam logic [27:0] Rcp1000  = 28'd137438954; // x < 2^27, S = 37
  localparam logic [17:0] Rcp3600  = 18'd149131;    // x < 2^17, S = 29
  localparam logic [12:0] Rcp60    = 13'd4370;      // x < 2^12, S = 18
  localparam logic [18:0] Rcp1460  = 19'd367720;    // x < 2^18, S = 29
  localparam logic [18:0] Rcp36524 = 19'd470373;    // x < 2^18, S = 34
  localparam logic [18:0] Rcp365   = 19'd367720;    // x < 2^18, S = 27
  localparam logic [9:0]  Rcp100   = 10'd656;       // x < 2^9,  S = 16
  localparam logic [11:0] Rcp153   = 12'd3427;      // x < 2^11, S = 19
  localparam logic [11:0] Rcp5     = 12'd3277;      // x < 2^11, S = 14

  localparam int DayDivStages = 5;
  localparam int EraDivStages = 3;
  localparam int SideDelay    = 19; // day split (6) plus civil date (13)
  localparam int TodDelay     = 7;  // civil date (13) minus clock split (6)

endpackage

`default_nettype wire

@@ src/ecd_shift.sv @@
// Input stage: offset range check, zone shift, overflow check and fold to magnitude.
// Depends on ecd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecd_shift (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ecd_pkg::ecd_in_t  req_i,
  output ecd_pkg::ecd_side_t side_o,
  output logic [62:0]       mag_o,
  output logic              neg_o
);
  import ecd_pkg::*;

  logic                a_vld_q;
  logic signed [63:0]  a_ms_q;
  logic signed [28:0]  a_dl_q, a_dl_d;
  logic                a_oor_q, a_oor_d;

  logic                b_vld_q;
  logic                b_err_q, b_err_d;
  logic                b_neg_q, b_neg_d;
  logic [62:0]         b_mag_q, b_mag_d;

  logic signed [63:0]  dl64;
  logic signed [63:0]  sum;

  always_comb begin
    a_dl_d  = 29'(req_i.offset_minutes) * MsPerMin;
    a_oor_d = (req_i.offset_minutes > OffMax) || (req_i.offset_minutes < OffMin);
  end

  always_comb begin
    dl64    = 64'(a_dl_q);
    sum     = a_ms_q + dl64;
    b_err_d = a_oor_q || ((a_ms_q[63] == dl64[63]) && (sum[63] != a_ms_q[63]));
    b_neg_d = sum[63];
    // fold negative values so the divider sees floor(-x) as ~x
    b_mag_d = sum[63] ? ~sum[62:0] : sum[62:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ms_q  <= req_i.epoch_ms;
    a_dl_q  <= a_dl_d;
    a_oor_q <= a_oor_d;
    b_err_q <= b_err_d;
    b_neg_q <= b_neg_d;
    b_mag_q <= b_mag_d;
  end

  assign side_o = '{vld: b_vld_q, err: b_err_q};
  assign mag_o  = b_mag_q;
  assign neg_o  = b_neg_q;

endmodule

`default_nettype wire

@@ src/ecd_day_split.sv @@
// Floor division of the shifted instant by one day: pipelined restoring divider.
// Depends on ecd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ecd_day_split (
  input  logic               clk_i,
  input  logic [62:0]        mag_i,
  input  logic               neg_i,
  output logic signed [37:0] days_o,
  output logic [26:0]        msod_o
);
  import ecd_pkg::*;

  logic [26:0] rem_in [DayDivStages];
  logic [36:0] quo_in [DayDivStages];
  logic [36:0] low_in [DayDivStages];
  logic        neg_in [DayDivStages];

  logic [26:0] rem_q [DayDivStages];
  logic [36:0] quo_q [DayDivStages];
  logic [36:0] low_q [DayDivStages];
  logic        neg_q [DayDivStages];

  logic signed [37:0] days_q, days_d;
  logic [26:0]        msod_q, msod_d;

  // top 26 bits are below the divisor, so they seed the remainder
  assign rem_in[0] = {1'b0, mag_i[62:37]};
  assign quo_in[0] = '0;
  assign low_in[0] = mag_i[36:0];
  assign neg_in[0] = neg_i;

  for (genvar s = 0; s < DayDivStages; s++) begin : g_div
    logic [26:0] r;
    logic [36:0] q;
    logic [27:0] t;

    if (s > 0) begin : g_link
      assign rem_in[s] = rem_q[s-1];
      assign quo_in[s] = quo_q[s-1];
      assign low_in[s] = low_q[s-1];
      assign neg_in[s] = neg_q[s-1];
    end

    // up to eight quotient bits per stage (five in the last stage), MSB first
    always_comb begin
      r = rem_in[s];
      q = quo_in[s];
      t = '0;
      for (int k = 0; (k < 8) && (36 - 8*s - k >= 0); k++) begin
        t = {r, low_in[s][36 - 8*s - k]};
        if (t >= {1'b0, MsPerDay}) begin
          r = 27'(t - {1'b0, MsPerDay});
          q[36 - 8*s - k] = 1'b1;
        end else begin
          r = t[26:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= r;
      quo_q[s] <= q;
      low_q[s] <= low_in[s];
      neg_q[s] <= neg_in[s];
    end
  end

  always_comb begin
    days_d = neg_q[DayDivStages-1] ? ~{1'b0, quo_q[DayDivStages-1]}
                                   : {1'b0, quo_q[DayDivStages-1]};
    msod_d = neg_q[DayDivStages-1] ? 27'(MsPerDay - 27'd1 - rem_q[DayDivStages-1])
                                   : rem_q[DayDivStages-1];
  end

  always_ff @(posedge clk_i) begin
    days_q <= days_d;
    msod_q <= msod_d;
  end

  assign days_o = days_q;
  assign msod_o = msod_q;

endmodule

`default_nettype wire

@@ src/ecd_clock_split.sv @@
// Time of day: split the millisecond of the day into hour, minute, second, ms.
// Depends on ecd_pkg; six register stages, reciprocal multiply then back-multiply.
`timescale 1ns / 1ps
`default_nettype none

module ecd_clock_split (
  input  logic              clk_i,
  input  logic [26:0]       msod_i,
  output ecd_pkg::ecd_tod_t tod_o
);
  import ecd_pkg::*;

  logic [54:0] p1;
  logic [16:0] c1_q1_q;
  logic [26:0] c1_ms_q;

  logic [26:0] back2;
  logic [9:0]  c2_ms_q;
  logic [16:0] c2_sod_q;

  logic [34:0] p3;
  logic [4:0]  c3_hr_q;
  logic [16:0] c3_sod_q;
  logic [9:0]  c3_ms_q;

  logic [16:0] back4;
  logic [11:0] c4_r_q;
  logic [4:0]  c4_hr_q;
  logic [9:0]  c4_ms_q;

  logic [24:0] p5;
  logic [5:0]  c5_mi_q;
  logic [11:0] c5_r_q;
  logic [4:0]  c5_hr_q;
  logic [9:0]  c5_ms_q;

  logic [11:0] back6;
  ecd_tod_t    c6_q, c6_d;

  always_comb begin
    p1    = 55'(msod_i) * 55'(Rcp1000);
    back2 = 27'(c1_q1_q) * 27'd1000;
    p3    = 35'(c2_sod_q) * 35'(Rcp3600);
    back4 = 17'(c3_hr_q) * 17'd3600;
    p5    = 25'(c4_r_q) * 25'(Rcp60);
    back6 = 12'(c5_mi_q) * 12'd60;
    c6_d  = '{hour: c5_hr_q, minute: c5_mi_q, second: 6'(c5_r_q - back6),
              millisecond: c5_ms_q};
  end

  always_ff @(posedge clk_i) begin
    c1_q1_q  <= p1[53:37];
    c1_ms_q  <= msod_i;
    c2_ms_q  <= 10'(c1_ms_q - back2);
    c2_sod_q <= c1_q1_q;
    c3_hr_q  <= p3[33:29];
    c3_sod_q <= c2_sod_q;
    c3_ms_q  <= c2_ms_q;
    c4_r_q   <= 12'(c3_sod_q - back4);
    c4_hr_q  <= c3_hr_q;
    c4_ms_q  <= c3_ms_q;
    c5_mi_q  <= p5[23:18];
    c5_r_q   <= c4_r_q;
    c5_hr_q  <= c4_hr_q;
    c5_ms_q  <= c4_ms_q;
    c6_q     <= c6_d;
  end

  assign tod_o = c6_q;

endmodule

`default_nettype wire

@@ src/ecd_civil.sv @@
// Day count to proleptic Gregorian year, month, day (era / day-of-era method).
// Depends on ecd_pkg; thirteen register stages including a 3-stage era divider.
`timescale 1ns / 1ps
`default_nettype none

module ecd_civil (
  input  logic               clk_i,
  input  logic signed [37:0] days_i,
  output ecd_pkg::ecd_date_t date_o
);
  import ecd_pkg::*;

  logic signed [37:0] z;
  logic [36:0]        d0_w_q;
  logic               d0_n_q;

  logic [17:0] rem_in [EraDivStages];
  logic [19:0] quo_in [EraDivStages];
  logic [19:0] low_in [EraDivStages];
  logic        neg_in [EraDivStages];
  logic [17:0] rem_q  [EraDivStages];
  logic [19:0] quo_q  [EraDivStages];
  logic [19:0] low_q  [EraDivStages];
  logic        neg_q  [EraDivStages];

  logic signed [20:0] d4_era_q;
  logic [17:0]        d4_doe_q;

  logic [36:0]        pa, pb;
  logic [6:0]         d5_a_q;
  logic [2:0]         d5_b_q;
  logic               d5_c_q;
  logic [17:0]        d5_doe_q;
  logic signed [20:0] d5_era_q;

  logic [17:0]        d6_t_q;
  logic [17:0]        d6_doe_q;
  logic signed [20:0] d6_era_q;

  logic [36:0]        py;
  logic [8:0]         d7_yoe_q;
  logic [17:0]        d7_doe_q;
  logic signed [20:0] d7_era_q;

  logic [18:0]        pc;
  logic [17:0]        d8_p_q;
  logic [1:0]         d8_yc_q;
  logic signed [29:0] d8_e400_q;
  logic [8:0]         d8_yoe_q;
  logic [17:0]        d8_doe_q;

  logic [8:0]         d9_doy_q;
  logic signed [29:0] d9_yb_q;

  logic [10:0]        x10;
  logic [22:0]        pm;
  logic [3:0]         d10_mp_q;
  logic [8:0]         d10_doy_q;
  logic signed [29:0] d10_yb_q;

  logic [10:0]        d11_e_q;
  logic [3:0]         d11_mo_q;
  logic [8:0]         d11_doy_q;
  logic signed [29:0] d11_yb_q;

  logic [22:0]        pd;
  logic signed [29:0] y12;
  ecd_date_t          d12_q, d12_d;

  assign z = days_i + DayShift;

  always_ff @(posedge clk_i) begin
    d0_n_q <= z[37];
    d0_w_q <= z[37] ? ~z[36:0] : z[36:0];
  end

  // era divider: top 17 bits seed the remainder, 20 quotient bits follow
  assign rem_in[0] = {1'b0, d0_w_q[36:20]};
  assign quo_in[0] = '0;
  assign low_in[0] = d0_w_q[19:0];
  assign neg_in[0] = d0_n_q;

  for (genvar s = 0; s < EraDivStages; s++) begin : g_div
    logic [17:0] r;
    logic [19:0] q;
    logic [18:0] t;

    if (s > 0) begin : g_link
      assign rem_in[s] = rem_q[s-1];
      assign quo_in[s] = quo_q[s-1];
      assign low_in[s] = low_q[s-1];
      assign neg_in[s] = neg_q[s-1];
    end

    always_comb begin
      r = rem_in[s];
      q = quo_in[s];
      t = '0;
      for (int k = 0; (k < 8) && (19 - 8*s - k >= 0); k++) begin
        t = {r, low_in[s][19 - 8*s - k]};
        if (t >= {1'b0, EraDays}) begin
          r = 18'(t - {1'b0, EraDays});
          q[19 - 8*s - k] = 1'b1;
        end else begin
          r = t[17:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= r;
      quo_q[s] <= q;
      low_q[s] <= low_in[s];
      neg_q[s] <= neg_in[s];
    end
  end

  always_comb begin
    pa   = 37'(d4_doe_q) * 37'(Rcp1460);
    pb   = 37'(d4_doe_q) * 37'(Rcp36524);
    py   = 37'(d6_t_q) * 37'(Rcp365);
    pc   = 19'(d7_yoe_q) * 19'(Rcp100);
    x10  = 11'(11'(d9_doy_q) * 11'd5 + 11'd2);
    pm   = 23'(x10) * 23'(Rcp153);
    pd   = 23'(d11_e_q) * 23'(Rcp5);
    y12  = d11_yb_q + 30'((d11_mo_q <= 4'd2) ? 1 : 0);
    d12_d = '{year: y12,
              month: d11_mo_q,
              day: 5'(d11_doy_q - pd[22:14] + 9'd1),
              four_digit_year: !y12[29] && (y12 <= 30'sd9999)};
  end

  always_ff @(posedge clk_i) begin
    d4_era_q  <= neg_q[EraDivStages-1] ? ~{1'b0, quo_q[EraDivStages-1]}
                                       : {1'b0, quo_q[EraDivStages-1]};
    d4_doe_q  <= neg_q[EraDivStages-1] ? 18'(EraLast - rem_q[EraDivStages-1])
                                       : rem_q[EraDivStages-1];
    d5_a_q    <= pa[35:29];
    d5_b_q    <= pb[36:34];
    d5_c_q    <= (d4_doe_q == EraLast);
    d5_doe_q  <= d4_doe_q;
    d5_era_q  <= d4_era_q;
    d6_t_q    <= 18'(d5_doe_q - 18'(d5_a_q) + 18'(d5_b_q) - 18'(d5_c_q));
    d6_doe_q  <= d5_doe_q;
    d6_era_q  <= d5_era_q;
    d7_yoe_q  <= py[35:27];
    d7_doe_q  <= d6_doe_q;
    d7_era_q  <= d6_era_q;
    d8_p_q    <= 18'(18'(d7_yoe_q) * 18'd365 + 18'(d7_yoe_q[8:2]));
    d8_yc_q   <= pc[17:16];
    d8_e400_q <= 30'(d7_era_q) * 30'sd400;
    d8_yoe_q  <= d7_yoe_q;
    d8_doe_q  <= d7_doe_q;
    d9_doy_q  <= 9'(d8_doe_q - (d8_p_q - 18'(d8_yc_q)));
    d9_yb_q   <= d8_e400_q + 30'(d8_yoe_q);
    d10_mp_q  <= pm[22:19];
    d10_doy_q <= d9_doy_q;
    d10_yb_q  <= d9_yb_q;
    d11_e_q   <= 11'(11'(d10_mp_q) * 11'd153 + 11'd2);
    d11_mo_q  <= (d10_mp_q < 4'd10) ? 4'(d10_mp_q + 4'd3) : 4'(d10_mp_q - 4'd9);
    d11_doy_q <= d10_doy_q;
    d11_yb_q  <= d10_yb_q;
    d12_q     <= d12_d;
  end

  assign date_o = d12_q;

endmodule

`default_nettype wire

@@ src/epoch_ms_to_civil_datetime_unit.sv @@
// Epoch milliseconds plus zone offset to civil date and time, fully pipelined.
// Throughput: one word per cycle.
// The path is 2 shift + 6 day split + 13 civil date + 1 output stage; the day divider
// resolves up to 8 quotient bits per stage and the clock split runs beside the civil date.
// busy is always low: the pipeline never stalls and the receiver cannot hold results.
// Reset clears only the valid bits and the delayed error flags; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module epoch_ms_to_civil_datetime_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ecd_pkg::ecd_in_t  req_i,
  output logic              done_o,
  output ecd_pkg::ecd_out_t res_o
);
  import ecd_pkg::*;

  ecd_side_t          sh_side;
  logic [62:0]        sh_mag;
  logic               sh_neg;
  logic signed [37:0] days;
  logic [26:0]        msod;
  ecd_tod_t           tod;
  ecd_date_t          date;

  // valid and error flags ride alongside the data path
  ecd_side_t side_q [SideDelay];
  // time of day finishes early; hold it until the date catches up
  ecd_tod_t  tod_q  [TodDelay];

  logic      done_q;
  ecd_out_t  res_q, res_d;

  // Shift by the zone offset and check range and overflow (2 stages).
  ecd_shift u_shift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .side_o  (sh_side),
    .mag_o   (sh_mag),
    .neg_o   (sh_neg)
  );

  // Floor divide by one day: day count and millisecond of the day (6 stages).
  ecd_day_split u_day_split (
    .clk_i  (clk_i),
    .mag_i  (sh_mag),
    .neg_i  (sh_neg),
    .days_o (days),
    .msod_o (msod)
  );

  // Hour, minute, second, millisecond (6 stages).
  ecd_clock_split u_clock_split (
    .clk_i  (clk_i),
    .msod_i (msod),
    .tod_o  (tod)
  );

  // Year, month, day and the four-digit flag (13 stages).
  ecd_civil u_civil (
    .clk_i  (clk_i),
    .days_i (days),
    .date_o (date)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SideDelay; i++) begin
        side_q[i] <= '0;
      end
      done_q <= 1'b0;
    end else begin
      side_q[0] <= sh_side;
      for (int i = 1; i < SideDelay; i++) begin
        side_q[i] <= side_q[i-1];
      end
      done_q <= side_q[SideDelay-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tod_q[0] <= tod;
    for (int i = 1; i < TodDelay; i++) begin
      tod_q[i] <= tod_q[i-1];
    end
    res_q <= res_d;
  end

  // Drop every field to zero on an error word, keeping only the flag.
  always_comb begin
    if (side_q[SideDelay-1].err) begin
      res_d       = '0;
      res_d.error = 1'b1;
    end else begin
      res_d = '{year: date.year,
                month: date.month,
                day: date.day,
                hour: tod_q[TodDelay-1].hour,
                minute: tod_q[TodDelay-1].minute,
                second: tod_q[TodDelay-1].second,
                millisecond: tod_q[TodDelay-1].millisecond,
                four_digit_year: date.four_digit_year,
                error: 1'b0};
    end
  end

  assign busy   = 1'b0;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire
